### hw/rtl/dwsd_pkg.sv
// ----------------------------------------------------------------------------
// dwsd_pkg
// Shared constants, codes and interface types of the worker slot dispatcher.
// ----------------------------------------------------------------------------
package dwsd_pkg;

    // Sizing
    localparam int RADIOS          = 2;
    localparam int SLOTS_PER_RADIO = 9;
    localparam int TOTAL_SLOTS     = RADIOS * SLOTS_PER_RADIO;
    localparam int SEEN_ENTRIES    = 32;

    localparam int SLOT_IDX_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int SEEN_IDX_W = $clog2(SEEN_ENTRIES);

    // Field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 48;
    localparam int SLOT_W    = 5;
    localparam int OUTCOME_W = 3;
    localparam int STAMP_W   = 32;
    localparam int TIMEOUT_W = 20;
    localparam int SPLIT_W   = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TIMEOUT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT   = 1'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(20000);
    localparam logic [SPLIT_W-1:0]   SPLIT_RESET   = SPLIT_W'(5);

    // Item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_SIGHT   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_e;

    // Result codes
    typedef enum logic [OUTCOME_W-1:0] {
        OC_DISPATCHED = 3'd0,
        OC_IN_SLOT    = 3'd1,
        OC_RECENT     = 3'd2,
        OC_NO_IDLE    = 3'd3,
        OC_NO_SIGHT   = 3'd4
    } outcome_e;

    // Commands to the seen table: lookup, age and record are one-cycle pulses
    typedef struct packed {
        logic                 lookup;
        logic                 age;
        logic                 record;
        logic [ADDR_W-1:0]    address;
        logic [STAMP_W-1:0]   clock_ms;
        logic [TIMEOUT_W-1:0] timeout;
    } seen_cmd_t;

    // Status back from the seen table
    typedef struct packed {
        logic done;
        logic hit;
    } seen_sts_t;

endpackage

### hw/rtl/dedup_worker_slot_dispatcher.sv
// ----------------------------------------------------------------------------
// dedup_worker_slot_dispatcher
// Hands newly sighted device addresses to the first idle worker slot,
// suppressing addresses held by a busy slot or served within the timeout.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_stall  | op, device_address, done_slot
//  out      | out_valid / out_stall| outcome, slot, radio, address_out
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  One item at a time. A sighting that reaches the seen table makes one slot
//  memory read per slot, then one seen-table read per entry; one that ends
//  after the slot scan makes only the slot reads. A tick makes one aging
//  read per seen entry; release and unused ops go straight to the output
//  stage. Reset clears busy flags, seen valid flags, clock and
//  registers at once. A beat waiting in the output register does not block
//  the next input beat; only a second finished result waits for it.
// ----------------------------------------------------------------------------
module dedup_worker_slot_dispatcher (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dwsd_pkg::OP_W-1:0]      op,
    input  logic [dwsd_pkg::ADDR_W-1:0]    device_address,
    input  logic [dwsd_pkg::SLOT_W-1:0]    done_slot,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dwsd_pkg::OUTCOME_W-1:0] outcome,
    output logic [dwsd_pkg::SLOT_W-1:0]    slot,
    output logic                           radio,
    output logic [dwsd_pkg::ADDR_W-1:0]    address_out,
    // configuration
    input  logic                           cfg_we,
    input  logic [dwsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dwsd_pkg::*;

    localparam int SL_CNT_W = SLOT_IDX_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SLOT = 5'b00010,
        S_SEEN = 5'b00100,
        S_AGE  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;

    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [SPLIT_W-1:0]      split_reg;
    logic [STAMP_W-1:0]      clock_ms_reg;
    logic [ADDR_W-1:0]       addr_reg;

    logic [ADDR_W-1:0]       slot_mem [TOTAL_SLOTS];
    logic [ADDR_W-1:0]       sl_rd_reg;
    logic [TOTAL_SLOTS-1:0]  busy_reg;
    logic [SL_CNT_W-1:0]     sl_issue_reg;
    logic                    sl_cmp_vld_reg;
    logic [SLOT_IDX_W-1:0]   sl_cmp_idx_reg;
    logic                    sl_done_reg;
    logic                    slot_hit_reg;
    logic                    idle_found_reg;
    logic [SLOT_IDX_W-1:0]   idle_idx_reg;

    logic [OUTCOME_W-1:0]    res_outcome_reg;
    logic [SLOT_W-1:0]       res_slot_reg;
    logic                    res_radio_reg;
    logic [ADDR_W-1:0]       res_addr_reg;

    logic                    out_valid_reg;
    logic [OUTCOME_W-1:0]    outcome_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    radio_reg;
    logic [ADDR_W-1:0]       address_out_reg;

    logic                    accept_in;
    logic                    sl_issuing;
    logic                    dispatch;
    logic                    out_load;
    seen_cmd_t               seen_cmd;
    seen_sts_t               seen_sts;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept_in  = in_valid && (state_reg == S_IDLE);
    assign sl_issuing = (state_reg == S_SLOT) && (sl_issue_reg < SL_CNT_W'(TOTAL_SLOTS));
    assign dispatch   = (state_reg == S_SEEN) && seen_sts.done && !seen_sts.hit;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Seen table commands
    assign seen_cmd.lookup   = (state_reg == S_SLOT) && sl_done_reg && !slot_hit_reg
                               && idle_found_reg;
    assign seen_cmd.age      = accept_in && (op == OP_TICK);
    assign seen_cmd.record   = dispatch;
    assign seen_cmd.address  = addr_reg;
    assign seen_cmd.clock_ms = clock_ms_reg;
    assign seen_cmd.timeout  = timeout_reg;

    dwsd_seen_table u_seen (
        .clk (clk),
        .rst_n (rst_n),
        .cmd (seen_cmd),
        .sts (seen_sts)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            split_reg   <= SPLIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_SPLIT:   split_reg   <= cfg_data[SPLIT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    case (op)
                        OP_SIGHT: state_next = S_SLOT;
                        OP_TICK:  state_next = S_AGE;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_SLOT:
            begin
                if (sl_done_reg)
                begin
                    state_next = seen_cmd.lookup ? S_SEEN : S_OUT;
                end
            end
            S_SEEN:
            begin
                if (seen_sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_AGE:
            begin
                if (seen_sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Slot address memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (dispatch)
        begin
            slot_mem[idle_idx_reg] <= addr_reg;
        end
        if (sl_issuing)
        begin
            sl_rd_reg <= slot_mem[sl_issue_reg[SLOT_IDX_W-1:0]];
        end
    end

    // Control state, slot scan and busy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_ms_reg   <= '0;
            busy_reg       <= '0;
            sl_issue_reg   <= SL_CNT_W'(TOTAL_SLOTS);
            sl_cmp_vld_reg <= 1'b0;
            sl_cmp_idx_reg <= '0;
            sl_done_reg    <= 1'b0;
            slot_hit_reg   <= 1'b0;
            idle_found_reg <= 1'b0;
            idle_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // item entry
            if (accept_in)
            begin
                case (op)
                    OP_SIGHT:
                    begin
                        sl_issue_reg   <= '0;
                        slot_hit_reg   <= 1'b0;
                        idle_found_reg <= 1'b0;
                    end
                    OP_RELEASE:
                    begin
                        if (32'(done_slot) < 32'(TOTAL_SLOTS))
                        begin
                            busy_reg[SLOT_IDX_W'(done_slot)] <= 1'b0;
                        end
                    end
                    OP_TICK:  clock_ms_reg <= clock_ms_reg + STAMP_W'(1);
                    default:  ;
                endcase
            end
            else if (sl_issuing)
            begin
                sl_issue_reg <= sl_issue_reg + SL_CNT_W'(1);
            end

            // slot compare stage
            sl_cmp_vld_reg <= sl_issuing;
            sl_cmp_idx_reg <= sl_issue_reg[SLOT_IDX_W-1:0];
            sl_done_reg    <= sl_cmp_vld_reg
                              && (sl_cmp_idx_reg == SLOT_IDX_W'(TOTAL_SLOTS - 1));
            if (sl_cmp_vld_reg)
            begin
                if (busy_reg[sl_cmp_idx_reg])
                begin
                    if (sl_rd_reg == addr_reg)
                    begin
                        slot_hit_reg <= 1'b1;
                    end
                end
                else if (!idle_found_reg)
                begin
                    idle_found_reg <= 1'b1;
                    idle_idx_reg   <= sl_cmp_idx_reg;
                end
            end

            if (dispatch)
            begin
                busy_reg[idle_idx_reg] <= 1'b1;
            end

            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pending result and sighting address
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            addr_reg        <= device_address;
            res_outcome_reg <= OC_NO_SIGHT;
            res_slot_reg    <= '0;
            res_radio_reg   <= 1'b0;
            res_addr_reg    <= '0;
        end
        else if ((state_reg == S_SLOT) && sl_done_reg)
        begin
            if (slot_hit_reg)
            begin
                res_outcome_reg <= OC_IN_SLOT;
            end
            else if (!idle_found_reg)
            begin
                res_outcome_reg <= OC_NO_IDLE;
            end
        end
        else if ((state_reg == S_SEEN) && seen_sts.done)
        begin
            if (seen_sts.hit)
            begin
                res_outcome_reg <= OC_RECENT;
            end
            else
            begin
                res_outcome_reg <= OC_DISPATCHED;
                res_slot_reg    <= SLOT_W'(idle_idx_reg);
                res_radio_reg   <= (32'(idle_idx_reg) >= 32'(split_reg));
                res_addr_reg    <= addr_reg;
            end
        end

        if (out_load)
        begin
            outcome_reg     <= res_outcome_reg;
            slot_reg        <= res_slot_reg;
            radio_reg       <= res_radio_reg;
            address_out_reg <= res_addr_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign slot        = slot_reg;
    assign radio       = radio_reg;
    assign address_out = address_out_reg;

endmodule

### hw/rtl/dwsd_seen_table.sv
// ----------------------------------------------------------------------------
// dwsd_seen_table
// Recently-served table: address/stamp memory with per-entry valid flops.
// Runs a lookup scan (match plus first free entry) or an aging scan.
// ----------------------------------------------------------------------------
module dwsd_seen_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dwsd_pkg::seen_cmd_t  cmd,
    output dwsd_pkg::seen_sts_t  sts
);
    import dwsd_pkg::*;

    localparam int CNT_W = SEEN_IDX_W + 1;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    entry_t                  mem [SEEN_ENTRIES];
    entry_t                  rd_data_reg;
    logic [SEEN_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic                    cmp_vld_reg;
    logic [SEEN_IDX_W-1:0]   cmp_idx_reg;
    logic                    age_mode_reg;
    logic                    hit_reg;
    logic                    free_found_reg;
    logic [SEEN_IDX_W-1:0]   free_idx_reg;
    logic                    done_reg;

    logic                    issuing;
    logic [STAMP_W-1:0]      age;
    logic                    expired;
    logic                    do_record;

    assign issuing   = issue_reg < CNT_W'(SEEN_ENTRIES);
    assign age       = cmd.clock_ms - rd_data_reg.stamp;
    assign expired   = age > STAMP_W'(cmd.timeout);
    assign do_record = cmd.record && free_found_reg;

    // Memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (do_record)
        begin
            mem[free_idx_reg] <= '{addr: cmd.address, stamp: cmd.clock_ms};
        end
        if (issuing)
        begin
            rd_data_reg <= mem[issue_reg[SEEN_IDX_W-1:0]];
        end
    end

    // Scan control and compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            issue_reg      <= CNT_W'(SEEN_ENTRIES);
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            age_mode_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.lookup || cmd.age)
            begin
                issue_reg      <= '0;
                age_mode_reg   <= cmd.age;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (issuing)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end

            cmp_vld_reg <= issuing;
            cmp_idx_reg <= issue_reg[SEEN_IDX_W-1:0];
            done_reg    <= cmp_vld_reg && (cmp_idx_reg == SEEN_IDX_W'(SEEN_ENTRIES - 1));

            if (cmp_vld_reg)
            begin
                if (age_mode_reg)
                begin
                    // retire entries past the timeout
                    if (valid_reg[cmp_idx_reg] && expired)
                    begin
                        valid_reg[cmp_idx_reg] <= 1'b0;
                    end
                end
                else if (valid_reg[cmp_idx_reg])
                begin
                    if (rd_data_reg.addr == cmd.address)
                    begin
                        hit_reg <= 1'b1;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end

            if (do_record)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.hit  = hit_reg;

endmodule

### test/tb_dedup_worker_slot_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_worker_slot_dispatcher
// Drives sightings, slot releases, millisecond ticks and unused ops into the
// dispatcher. A scoreboard keeps its own copy of the slot and seen tables,
// predicts one result per accepted beat and checks each result beat in order.
// Several timeout / radio split settings are exercised, both channels idle in
// random bursts, and the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_dedup_worker_slot_dispatcher;

    import dwsd_pkg::*;

    localparam int POOL_SIZE      = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // One result beat
    typedef struct packed {
        outcome_e            outcome;
        logic [SLOT_W-1:0]   slot;
        logic                radio;
        logic [ADDR_W-1:0]   addr;
    } dispatch_t;

    // Slot / seen table tracker and result checker
    class dispatch_scoreboard;
        bit                  busy [TOTAL_SLOTS];
        logic [ADDR_W-1:0]   held_addr [TOTAL_SLOTS];
        bit                  seen_ok [SEEN_ENTRIES];
        logic [ADDR_W-1:0]   seen_addr [SEEN_ENTRIES];
        logic [STAMP_W-1:0]  seen_ms [SEEN_ENTRIES];
        logic [STAMP_W-1:0]  now_ms;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [SPLIT_W-1:0]  split_slot;
        dispatch_t           dispatch_q [$];
        int                  mismatch_count;

        function new();
            foreach (busy[i])
            begin
                busy[i]      = 1'b0;
                held_addr[i] = '0;
            end
            foreach (seen_ok[i])
            begin
                seen_ok[i]   = 1'b0;
                seen_addr[i] = '0;
                seen_ms[i]   = '0;
            end
            now_ms         = '0;
            timeout_ms     = TIMEOUT_RESET;
            split_slot     = SPLIT_RESET;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TIMEOUT)
                timeout_ms = val[TIMEOUT_W-1:0];
            else if (idx == CFG_SPLIT)
                split_slot = val[SPLIT_W-1:0];
        endfunction

        function int pending();
            return dispatch_q.size();
        endfunction

        // Apply one accepted input beat and queue the result it causes
        function void dispatch_item(op_e o, logic [ADDR_W-1:0] a, logic [SLOT_W-1:0] d);
            dispatch_t          r;
            int                 idle;
            int                 free_ent;
            bit                 hit;
            logic [STAMP_W-1:0] age;
            r = '{OC_NO_SIGHT, '0, 1'b0, '0};
            case (o)
                OP_SIGHT:
                begin
                    // busy match wins over everything, even with no idle slot
                    idle = -1;
                    hit  = 1'b0;
                    for (int i = 0; i < TOTAL_SLOTS; i++)
                    begin
                        if (busy[i])
                        begin
                            if (held_addr[i] == a)
                                hit = 1'b1;
                        end
                        else if (idle < 0)
                            idle = i;
                    end
                    if (hit)
                        r.outcome = OC_IN_SLOT;
                    else if (idle < 0)
                        r.outcome = OC_NO_IDLE;
                    else
                    begin
                        // seen table only consulted when a slot is free
                        free_ent = -1;
                        for (int i = 0; i < SEEN_ENTRIES; i++)
                        begin
                            if (seen_ok[i])
                            begin
                                if (seen_addr[i] == a)
                                    hit = 1'b1;
                            end
                            else if (free_ent < 0)
                                free_ent = i;
                        end
                        if (hit)
                            r.outcome = OC_RECENT;
                        else
                        begin
                            // full table: dispatch anyway, no record
                            if (free_ent >= 0)
                            begin
                                seen_ok[free_ent]   = 1'b1;
                                seen_addr[free_ent] = a;
                                seen_ms[free_ent]   = now_ms;
                            end
                            busy[idle]      = 1'b1;
                            held_addr[idle] = a;
                            r = '{OC_DISPATCHED, SLOT_W'(idle),
                                  (idle >= int'(split_slot)), a};
                        end
                    end
                end
                OP_RELEASE:
                begin
                    if (d < TOTAL_SLOTS)
                    begin
                        busy[d]      = 1'b0;
                        held_addr[d] = '0;
                    end
                end
                OP_TICK:
                begin
                    // advance clock, then retire stale entries
                    now_ms = now_ms + 1'b1;
                    for (int i = 0; i < SEEN_ENTRIES; i++)
                    begin
                        age = now_ms - seen_ms[i];
                        if (seen_ok[i] && age > STAMP_W'(timeout_ms))
                        begin
                            seen_ok[i]   = 1'b0;
                            seen_addr[i] = '0;
                            seen_ms[i]   = '0;
                        end
                    end
                end
                default: ;
            endcase
            dispatch_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_beat(logic [OUTCOME_W-1:0] oc, logic [SLOT_W-1:0] sl,
                                 logic rd, logic [ADDR_W-1:0] ad);
            dispatch_t e;
            if (dispatch_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: outcome %0d slot %0d radio %0d addr %h",
                             oc, sl, rd, ad);
                return;
            end
            e = dispatch_q.pop_front();
            if (oc !== e.outcome || sl !== e.slot || rd !== e.radio || ad !== e.addr)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $write("result mismatch: expected outcome %0d slot %0d radio %0d addr %h, ",
                           e.outcome, e.slot, e.radio, e.addr);
                    $display("got outcome %0d slot %0d radio %0d addr %h", oc, sl, rd, ad);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_stall;
    logic [OP_W-1:0]       op;
    logic [ADDR_W-1:0]     device_address;
    logic [SLOT_W-1:0]     done_slot;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUTCOME_W-1:0]  outcome;
    logic [SLOT_W-1:0]     slot;
    logic                  radio;
    logic [ADDR_W-1:0]     address_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];
    bit                    idle_en;
    bit                    hold_req;
    int                    quiet_cycles = 0;

    dispatch_scoreboard    sb = new();

    dedup_worker_slot_dispatcher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .device_address (device_address),
        .done_slot      (done_slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .slot           (slot),
        .radio          (radio),
        .address_out    (address_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Result beats go straight to the checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(outcome, slot, radio, address_out);
    end

    // Watchdog: too many cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** dedup_worker_slot_dispatcher: FAILED **");
                $finish;
            end
        end
    end

    // Output backpressure: random bursts, plus one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one beat and hold it until accepted; valid stays high afterwards
    task automatic send_beat(input op_e o, input logic [ADDR_W-1:0] a,
                             input logic [SLOT_W-1:0] d);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        device_address <= a;
        done_slot      <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.dispatch_item(o, a, d);
    endtask

    // Stop sending and wait for every predicted result to come back
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write both registers back to back; only called while idle
    task automatic write_regs(input logic [TIMEOUT_W-1:0] tmo, input logic [SPLIT_W-1:0] split);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(tmo);
        @(posedge clk);
        sb.write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        cfg_index <= CFG_SPLIT;
        cfg_data  <= CFG_DATA_W'(split);
        @(posedge clk);
        sb.write_reg(CFG_SPLIT, CFG_DATA_W'(split));
        cfg_we    <= 1'b0;
    endtask

    // Random mix, sightings mostly drawn from a small pool to force repeats
    task automatic run_phase(input int count);
        int                pick;
        op_e               o;
        logic [ADDR_W-1:0] a;
        logic [SLOT_W-1:0] d;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            a    = ADDR_W'({$urandom, $urandom});
            d    = SLOT_W'($urandom);
            if (pick < 50)
            begin
                o = OP_SIGHT;
                if ($urandom_range(0, 9) != 0)
                    a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else if (pick < 80)
            begin
                o = OP_RELEASE;
                if ($urandom_range(0, 9) == 0)
                    d = SLOT_W'($urandom_range(TOTAL_SLOTS, 31));
                else
                    d = SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
            end
            else if (pick < 95)
                o = OP_TICK;
            else
                o = OP_NONE;
            send_beat(o, a, d);
        end
    endtask

    initial
    begin
        in_valid       = 1'b0;
        op             = OP_NONE;
        device_address = '0;
        done_slot      = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_TIMEOUT;
        cfg_data       = '0;
        idle_en        = 1'b1;
        hold_req       = 1'b0;
        foreach (addr_pool[i])
            addr_pool[i] = ADDR_W'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, extremes and each special case
        send_beat(OP_NONE, '1, 5'd31);          // unused op does nothing
        send_beat(OP_SIGHT, '0, '0);            // dispatched to slot 0
        send_beat(OP_SIGHT, '0, 5'd31);         // already in a slot
        send_beat(OP_SIGHT, '1, '0);            // slot 1
        send_beat(OP_RELEASE, '1, 5'd0);        // free slot 0
        send_beat(OP_SIGHT, '0, '0);            // served recently
        send_beat(OP_RELEASE, '0, 5'd31);       // out-of-range slot ignored
        send_beat(OP_TICK, '1, 5'd31);
        for (int k = 0; k < TOTAL_SLOTS - 1; k++)
            send_beat(OP_SIGHT, 48'h5A5A_0000_0000 + ADDR_W'(k), '0);  // crosses split
        send_beat(OP_SIGHT, 48'h0123_4567_89AB, '0);  // no idle slot
        send_beat(OP_SIGHT, '1, '0);            // busy match while all full
        wait_results();

        // Immediate aging, everything on radio one
        write_regs('0, 5'd0);
        run_phase(250);
        wait_results();

        // Short timeout, everything on radio zero
        write_regs(20'd3, 5'(TOTAL_SLOTS));
        run_phase(250);
        wait_results();

        // Nothing ages out, so the seen table fills
        write_regs('1, 5'd9);
        run_phase(280);
        wait_results();

        // Long output hold while input keeps coming, then a full pause
        write_regs(20'd40, 5'd1);
        hold_req = 1'b1;
        run_phase(140);
        wait_results();
        run_phase(140);
        wait_results();

        // Tail with no idling on either side
        write_regs(20'd7, 5'd17);
        idle_en = 1'b0;
        run_phase(270);
        wait_results();
        repeat (100) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("** dedup_worker_slot_dispatcher: PASSED **");
        else
            $display("** dedup_worker_slot_dispatcher: FAILED **");
        $finish;
    end

endmodule
